// ===== hdl/gbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types, constants and modular add for the grid boundary exit counter.
// ----------------------------------------------------------------------------
package gbe_pkg;

	localparam int CNT_W = 30;
	localparam int CRD_W = 7;
	localparam int SEQ_W = 8;
	localparam logic [CNT_W-1:0] COUNT_MOD = 30'd1000000007;

	localparam int DEF_MAX_ROWS  = 32;
	localparam int DEF_MAX_COLS  = 32;
	localparam int DEF_MAX_MOVES = 63;

	localparam logic [1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [1:0] REG_GRID_COLS = 2'd1;

	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_CLR  = 3'd1;
	localparam logic [2:0] OP_STEP = 3'd2;
	localparam logic [2:0] OP_MASK = 3'd3;
	localparam logic [2:0] OP_SHR  = 3'd4;
	localparam logic [2:0] OP_SHC  = 3'd5;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CRD_W-1:0] crd_t;

	typedef struct packed {
		logic [2:0] op;
		crd_t       rows;
		crd_t       cols;
		crd_t       srow;
		crd_t       scol;
	} cell_ctl_t;

	function automatic cnt_t mod_add(cnt_t a, cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, COUNT_MOD})
			s = s - {1'b0, COUNT_MOD};
		return s[CNT_W-1:0];
	endfunction

endpackage

// ===== hdl/grid_boundary_exit_path_count.sv =====
// ----------------------------------------------------------------------------
// grid_boundary_exit_path_count
// Counts walks of at most a given number of moves that leave the grid,
// modulo 1000000007, on a cell array padded with a ring of exit sinks.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: move_budget, start_row, start_col
//  m_*      out  tvalid/tready      tdata: path_count; tuser: bad_start
//  cfg_*    in   cfg_we             cfg_addr, cfg_wdata
//
//  Each query runs a clear, the move steps, a mask, row shifts, column shifts and
//  the result.
//  The cell array takes one move per cycle; the sums shift out to the corner.
//  A start cell outside the grid skips the array and returns a zero count with bad_start set.
//  One query at a time; a held result does not block accepting the next word.
//  Reset clears control state and sets the grid to 1 by 1.
// ----------------------------------------------------------------------------
module grid_boundary_exit_path_count #(
	parameter int MAX_ROWS  = gbe_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS  = gbe_pkg::DEF_MAX_COLS,
	parameter int MAX_MOVES = gbe_pkg::DEF_MAX_MOVES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // move_budget[5:0], start_row[10:6], start_col[15:11]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // path_count[29:0], zero[31:30]
	output logic        m_tuser,   // bad_start
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [5:0]  cfg_wdata
);
	import gbe_pkg::*;

	localparam int PR = MAX_ROWS + 2;
	localparam int PC = MAX_COLS + 2;

	logic [5:0] rows_q, cols_q;
	cell_ctl_t  ctl;
	cnt_t       val_w [PR][PC];
	cnt_t       em_w  [PR][PC];
	cnt_t       path_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 6'd1;
			cols_q <= 6'd1;
		end else if (cfg_we) begin
			if (cfg_addr == REG_GRID_ROWS)
				rows_q <= cfg_wdata;
			else if (cfg_addr == REG_GRID_COLS)
				cols_q <= cfg_wdata;
		end
	end

	for (genvar r = 0; r < PR; r++) begin : g_row
		for (genvar c = 0; c < PC; c++) begin : g_col
			cnt_t n_em, s_em, e_em, w_em, e_val, s_val;
			if (r > 0) begin : g_n
				assign n_em = em_w[r-1][c];
			end else begin : g_nz
				assign n_em = '0;
			end
			if (r < PR - 1) begin : g_s
				assign s_em  = em_w[r+1][c];
				assign s_val = val_w[r+1][c];
			end else begin : g_sz
				assign s_em  = '0;
				assign s_val = '0;
			end
			if (c > 0) begin : g_w
				assign w_em = em_w[r][c-1];
			end else begin : g_wz
				assign w_em = '0;
			end
			if (c < PC - 1) begin : g_e
				assign e_em  = em_w[r][c+1];
				assign e_val = val_w[r][c+1];
			end else begin : g_ez
				assign e_em  = '0;
				assign e_val = '0;
			end
			gbe_cell #(.ROW(r), .COL(c)) u_cell (
				.clk   (clk),
				.ctl   (ctl),
				.n_em  (n_em),
				.s_em  (s_em),
				.e_em  (e_em),
				.w_em  (w_em),
				.e_val (e_val),
				.s_val (s_val),
				.val   (val_w[r][c]),
				.em    (em_w[r][c])
			);
		end
	end

	gbe_ctl #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_MOVES (MAX_MOVES)
	) u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.move_budget (s_tdata[5:0]),
		.start_row   (s_tdata[10:6]),
		.start_col   (s_tdata[15:11]),
		.rows_q      (rows_q),
		.cols_q      (cols_q),
		.corner      (val_w[0][0]),
		.ctl         (ctl),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.path_count  (path_count),
		.bad_start   (m_tuser)
	);

	assign m_tdata = {2'b00, path_count};

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[29:0] == '0)
		else $error("bad start with nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:0] < COUNT_MOD)
		else $error("count not reduced");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a word while busy");

endmodule

// ===== hdl/gbe_cell.sv =====
// ----------------------------------------------------------------------------
// gbe_cell
// One grid cell: live walk count inside the grid, exit sink outside it,
// and a shift stage for the final summation.
// ----------------------------------------------------------------------------
module gbe_cell #(
	parameter int ROW = 0,
	parameter int COL = 0
) (
	input  logic                    clk,
	input  gbe_pkg::cell_ctl_t      ctl,
	input  gbe_pkg::cnt_t           n_em,
	input  gbe_pkg::cnt_t           s_em,
	input  gbe_pkg::cnt_t           e_em,
	input  gbe_pkg::cnt_t           w_em,
	input  gbe_pkg::cnt_t           e_val,
	input  gbe_pkg::cnt_t           s_val,
	output gbe_pkg::cnt_t           val,
	output gbe_pkg::cnt_t           em
);
	import gbe_pkg::*;

	localparam crd_t RI = CRD_W'(ROW);
	localparam crd_t CI = CRD_W'(COL);

	cnt_t v_q;
	cnt_t nxt;
	cnt_t in_sum;
	logic active;

	assign active = (RI != '0) && (RI <= ctl.rows) && (CI != '0) && (CI <= ctl.cols);
	assign in_sum = mod_add(mod_add(n_em, s_em), mod_add(e_em, w_em));

	always_comb begin
		unique case (ctl.op)
			OP_CLR:  nxt = (RI == ctl.srow && CI == ctl.scol) ? CNT_W'(1) : '0;
			OP_STEP: nxt = active ? in_sum : mod_add(v_q, in_sum);
			OP_MASK: nxt = active ? '0 : v_q;
			OP_SHR:  nxt = (CI == '0) ? mod_add(v_q, e_val) : e_val;
			OP_SHC:  nxt = (RI == '0) ? mod_add(v_q, s_val) : s_val;
			default: nxt = v_q;
		endcase
	end

	always_ff @(posedge clk) begin
		v_q <= nxt;
	end

	assign val = v_q;
	assign em  = active ? v_q : '0;

endmodule

// ===== hdl/gbe_ctl.sv =====
// ----------------------------------------------------------------------------
// gbe_ctl
// Query sequencer: clear, move steps, sink masking, summation shifts, result.
// ----------------------------------------------------------------------------
module gbe_ctl #(
	parameter int MAX_ROWS  = gbe_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS  = gbe_pkg::DEF_MAX_COLS,
	parameter int MAX_MOVES = gbe_pkg::DEF_MAX_MOVES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [5:0]         move_budget,
	input  logic [4:0]         start_row,
	input  logic [4:0]         start_col,
	input  logic [5:0]         rows_q,
	input  logic [5:0]         cols_q,
	input  gbe_pkg::cnt_t      corner,
	output gbe_pkg::cell_ctl_t ctl,
	output logic               out_valid,
	input  logic               out_ready,
	output gbe_pkg::cnt_t      path_count,
	output logic               bad_start
);
	import gbe_pkg::*;

	localparam int PR = MAX_ROWS + 2;
	localparam int PC = MAX_COLS + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_MASK = 3'd3;
	localparam logic [2:0] ST_SHR  = 3'd4;
	localparam logic [2:0] ST_SHC  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]     state_q;
	logic [SEQ_W-1:0] cnt_q;
	crd_t           srow_q, scol_q;
	logic           bad_q;
	logic           out_valid_q;
	cnt_t           count_q;
	logic           bad_out_q;
	crd_t           rows_eff, cols_eff;
	logic [SEQ_W-1:0] budget_eff;
	logic           start_bad;
	logic           accept;

	assign rows_eff = (rows_q == '0) ? CRD_W'(1) :
		({1'b0, rows_q} > CRD_W'(MAX_ROWS)) ? CRD_W'(MAX_ROWS) : {1'b0, rows_q};
	assign cols_eff = (cols_q == '0) ? CRD_W'(1) :
		({1'b0, cols_q} > CRD_W'(MAX_COLS)) ? CRD_W'(MAX_COLS) : {1'b0, cols_q};
	assign budget_eff = (SEQ_W'(move_budget) > SEQ_W'(MAX_MOVES)) ?
		SEQ_W'(MAX_MOVES) : SEQ_W'(move_budget);
	assign start_bad = (CRD_W'(start_row) >= rows_eff) || (CRD_W'(start_col) >= cols_eff);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctl.rows = rows_eff;
		ctl.cols = cols_eff;
		ctl.srow = srow_q;
		ctl.scol = scol_q;
		unique case (state_q)
			ST_CLR:  ctl.op = OP_CLR;
			ST_STEP: ctl.op = OP_STEP;
			ST_MASK: ctl.op = OP_MASK;
			ST_SHR:  ctl.op = OP_SHR;
			ST_SHC:  ctl.op = OP_SHC;
			default: ctl.op = OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bad_q   <= start_bad;
						cnt_q   <= budget_eff;
						state_q <= start_bad ? ST_OUT : ST_CLR;
					end
				end
				ST_CLR: begin
					state_q <= (cnt_q == '0) ? ST_MASK : ST_STEP;
				end
				ST_STEP: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == SEQ_W'(1))
						state_q <= ST_MASK;
				end
				ST_MASK: begin
					cnt_q   <= SEQ_W'(PC - 1);
					state_q <= ST_SHR;
				end
				ST_SHR: begin
					if (cnt_q == SEQ_W'(1)) begin
						cnt_q   <= SEQ_W'(PR - 1);
						state_q <= ST_SHC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SHC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == SEQ_W'(1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			srow_q <= CRD_W'(start_row) + CRD_W'(1);
			scol_q <= CRD_W'(start_col) + CRD_W'(1);
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			count_q   <= bad_q ? '0 : corner;
			bad_out_q <= bad_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign path_count = count_q;
	assign bad_start  = bad_out_q;

endmodule
